FILE: rtl/core/utf8cw_pkg.sv
package utf8cw_pkg;

    // Lead byte ranges for multi-byte sequences.
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] BYTE_NUL = 8'h00;

    // Sequence lengths as held in the decoder state.
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // Code point limits.
    localparam logic [20:0] MIN_CP3     = 21'h000800;
    localparam logic [20:0] MIN_CP4     = 21'h010000;
    localparam logic [20:0] MAX_CP      = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] WIDE_FROM   = 21'h01F300;

    // One decoded byte's worth of results: a run of replacement characters
    // followed by an optional tail result.
    typedef struct packed {
        logic [2:0]  rep;
        logic        tail;
        logic [20:0] cp;
        logic [1:0]  width;
        logic        end_mark;
    } t_run;

    // Terminal column count of a code point.
    function automatic logic [1:0] cell_width(input logic [20:0] c);
        logic zero_w;
        logic wide_w;
        zero_w = (c < 21'h20) || (c >= 21'h7F && c < 21'hA0) ||
                 (c >= 21'h300 && c <= 21'h36F) || (c >= 21'hFE00 && c <= 21'hFE0F);
        wide_w = (c >= 21'h1100 && c <= 21'h115F) || (c >= 21'h2E80 && c <= 21'hA4CF) ||
                 (c >= 21'hAC00 && c <= 21'hD7A3) || (c >= 21'hF900 && c <= 21'hFAFF) ||
                 (c >= 21'hFE10 && c <= 21'hFE6F) || (c >= 21'hFF01 && c <= 21'hFF60) ||
                 (c >= WIDE_FROM);
        if (zero_w) begin
            return 2'd0;
        end else if (wide_w) begin
            return 2'd2;
        end else begin
            return 2'd1;
        end
    endfunction

endpackage

FILE: rtl/core/utf8cw_decode.sv
module utf8cw_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_byte,
    input  logic              i_take,
    output utf8cw_pkg::t_run  o_run
);

    typedef struct packed {
        logic        tail;
        logic [20:0] cp;
        logic [2:0]  len;
        logic [20:0] pv;
        logic [2:0]  rcv;
    } t_lead;

    logic [20:0] r_partial, n_partial;
    logic [2:0]  r_exp, n_exp;
    logic [2:0]  r_rcv, n_rcv;
    logic [20:0] acc;
    logic [2:0]  cnt;
    logic        bad;
    t_lead       lead;

    // Handling of a byte with no sequence pending.
    function automatic t_lead lead_of(input logic [7:0] b);
        t_lead l;
        l = '0;
        if (!b[7]) begin
            l.tail = 1'b1;
            l.cp   = {13'd0, b};
        end else if (b >= utf8cw_pkg::LEAD2_LO && b <= utf8cw_pkg::LEAD2_HI) begin
            l.len = utf8cw_pkg::LEN_2;
            l.pv  = {16'd0, b[4:0]};
            l.rcv = 3'd1;
        end else if (b >= utf8cw_pkg::LEAD3_LO && b <= utf8cw_pkg::LEAD3_HI) begin
            l.len = utf8cw_pkg::LEN_3;
            l.pv  = {17'd0, b[3:0]};
            l.rcv = 3'd1;
        end else if (b >= utf8cw_pkg::LEAD4_LO && b <= utf8cw_pkg::LEAD4_HI) begin
            l.len = utf8cw_pkg::LEN_4;
            l.pv  = {18'd0, b[2:0]};
            l.rcv = 3'd1;
        end else begin
            l.tail = 1'b1;
            l.cp   = utf8cw_pkg::REPLACEMENT;
        end
        return l;
    endfunction

    assign lead = lead_of(i_byte);
    assign acc  = {r_partial[14:0], i_byte[5:0]};
    assign cnt  = r_rcv + 3'd1;
    assign bad  = (r_exp == utf8cw_pkg::LEN_3 && acc < utf8cw_pkg::MIN_CP3) ||
                  (r_exp == utf8cw_pkg::LEN_4 && acc < utf8cw_pkg::MIN_CP4) ||
                  (acc > utf8cw_pkg::MAX_CP) ||
                  (acc >= utf8cw_pkg::SURR_LO && acc <= utf8cw_pkg::SURR_HI);

    // Next sequence state and the results this byte causes.
    always_comb begin
        n_partial = r_partial;
        n_exp     = r_exp;
        n_rcv     = r_rcv;
        o_run     = '0;
        if (i_byte == utf8cw_pkg::BYTE_NUL) begin
            // Terminator flushes pending bytes, then reports the end.
            o_run.rep      = (r_exp != utf8cw_pkg::LEN_NONE) ? r_rcv : 3'd0;
            o_run.tail     = 1'b1;
            o_run.end_mark = 1'b1;
            n_partial      = '0;
            n_exp          = utf8cw_pkg::LEN_NONE;
            n_rcv          = '0;
        end else if (r_exp != utf8cw_pkg::LEN_NONE && i_byte[7:6] == 2'b10) begin
            if (cnt >= r_exp) begin
                if (bad) begin
                    o_run.rep = r_exp;
                end else begin
                    o_run.tail  = 1'b1;
                    o_run.cp    = acc;
                    o_run.width = utf8cw_pkg::cell_width(acc);
                end
                n_partial = '0;
                n_exp     = utf8cw_pkg::LEN_NONE;
                n_rcv     = '0;
            end else begin
                n_partial = acc;
                n_rcv     = cnt;
            end
        end else begin
            // A broken sequence flushes its bytes; the byte then starts afresh.
            if (r_exp != utf8cw_pkg::LEN_NONE) begin
                o_run.rep = r_rcv;
            end
            o_run.tail  = lead.tail;
            o_run.cp    = lead.cp;
            o_run.width = utf8cw_pkg::cell_width(lead.cp);
            n_partial   = lead.pv;
            n_exp       = lead.len;
            n_rcv       = lead.rcv;
        end
    end

    // Sequence state advances when the byte leaves the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_exp     <= utf8cw_pkg::LEN_NONE;
            r_rcv     <= '0;
        end else if (i_take) begin
            r_partial <= n_partial;
            r_exp     <= n_exp;
            r_rcv     <= n_rcv;
        end
    end

endmodule

FILE: rtl/core/utf8_decode_with_cell_width.sv
// Bytes pass the input register, then the decoder, into the result register.
// Throughput: one input byte per cycle while each gives at most one result and output
// is not stalled; a byte with N results holds the result register until all are taken.
// Bytes that only open or extend a sequence pass with no result and no stall.
// Reset (synchronous, active low) empties both stages and clears any pending sequence.
module utf8_decode_with_cell_width (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [20:0] o_code_point,
    output logic [1:0]  o_cell_width,
    output logic        o_end_marker,
    output logic        o_last_of_run
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    utf8cw_pkg::t_run run;
    logic             run_empty;
    logic             take;
    logic             load;
    logic             last;
    logic             free;

    logic             r_out_valid;
    logic [2:0]       r_rep;
    logic             r_tail;
    logic [20:0]      r_cp;
    logic [1:0]       r_width;
    logic             r_end;

    utf8cw_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (r_in_byte),
        .i_take  (take),
        .o_run   (run)
    );

    // Stage hand-off: a byte with no result never waits on the result register.
    assign run_empty  = (run.rep == 3'd0) && !run.tail;
    assign last       = (r_rep == 3'd0) || (r_rep == 3'd1 && !r_tail);
    assign free       = !r_out_valid || (last && i_out_ready);
    assign take       = r_in_valid && (run_empty || free);
    assign load       = take && !run_empty;
    assign o_in_ready = !r_in_valid || take;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Result register: plays out the replacement run, then the tail.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rep       <= '0;
            r_tail      <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_rep       <= run.rep;
            r_tail      <= run.tail;
        end else if (r_out_valid && i_out_ready) begin
            if (last) begin
                r_out_valid <= 1'b0;
            end else begin
                r_rep <= r_rep - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp    <= run.cp;
            r_width <= run.width;
            r_end   <= run.end_mark;
        end
    end

    // Result beat fields.
    assign o_out_valid   = r_out_valid;
    assign o_code_point  = (r_rep != 3'd0) ? utf8cw_pkg::REPLACEMENT : r_cp;
    assign o_cell_width  = (r_rep != 3'd0) ? utf8cw_pkg::cell_width(utf8cw_pkg::REPLACEMENT)
                                           : r_width;
    assign o_end_marker  = (r_rep == 3'd0) && r_end;
    assign o_last_of_run = last;

endmodule

FILE: rtl/core/utf8cw_checker.sv
module utf8cw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [20:0] o_code_point,
    input logic [1:0]  o_cell_width,
    input logic        o_end_marker,
    input logic        o_last_of_run
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_code_point) &&
        $stable(o_end_marker) && $stable(o_last_of_run))
        else $error("result beat changed while stalled");

    // The end beat carries code point 0, width 0 and closes its run.
    a_end_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_marker |->
        o_code_point == 21'd0 && o_cell_width == 2'd0 && o_last_of_run)
        else $error("malformed end beat");

    // A beat that is not the last of its run is always a replacement.
    a_run_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> o_code_point == 21'h00FFFD && !o_end_marker)
        else $error("non-final beat is not a replacement");

    // Width is never the unused code and code points stay in range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cell_width != 2'd3 && o_code_point <= 21'h10FFFF)
        else $error("result out of range");

endmodule

bind utf8_decode_with_cell_width utf8cw_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_code_point  (o_code_point),
    .o_cell_width  (o_cell_width),
    .o_end_marker  (o_end_marker),
    .o_last_of_run (o_last_of_run)
);

FILE: bench/tb_utf8_decode_with_cell_width.sv
`timescale 1ns / 1ps

module tb_utf8_decode_with_cell_width;

    // One expected result beat.
    typedef struct packed {
        logic [20:0] cp;
        logic [1:0]  cols;
        logic        term;
        logic        last;
    } t_decoded;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [20:0] code_point;
    logic [1:0]  cols_out;
    logic        end_marker;
    logic        last_of_run;

    // Bytes waiting to be sent and decoded characters waiting to arrive.
    logic [7:0]  byte_q[$];
    t_decoded    decoded_q[$];
    int          bytes_queued = 0;
    int          err_count    = 0;
    int          idle_pct     = 0;
    int          stall_pct    = 0;

    // Decoder state mirrored by the testbench.
    logic [20:0] acc_bits  = '0;
    logic [2:0]  seq_len   = utf8cw_pkg::LEN_NONE;
    logic [2:0]  seq_got   = '0;
    t_decoded    held;
    bit          have_held;
    int          run_len;

    always #2 clk = ~clk;

    utf8_decode_with_cell_width dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_byte     (in_byte),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_code_point  (code_point),
        .o_cell_width  (cols_out),
        .o_end_marker  (end_marker),
        .o_last_of_run (last_of_run)
    );

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic bit in_span(input logic [20:0] c, input logic [20:0] lo,
                                   input logic [20:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    // Terminal columns taken by a code point.
    function automatic logic [1:0] columns_of(input logic [20:0] c);
        if (in_span(c, 21'h0, 21'h1F) || in_span(c, 21'h7F, 21'h9F) ||
            in_span(c, 21'h300, 21'h36F) || in_span(c, 21'hFE00, 21'hFE0F)) begin
            return 2'd0;
        end
        if (in_span(c, 21'h1100, 21'h115F) || in_span(c, 21'h2E80, 21'hA4CF) ||
            in_span(c, 21'hAC00, 21'hD7A3) || in_span(c, 21'hF900, 21'hFAFF) ||
            in_span(c, 21'hFE10, 21'hFE6F) || in_span(c, 21'hFF01, 21'hFF60) ||
            c >= utf8cw_pkg::WIDE_FROM) begin
            return 2'd2;
        end
        return 2'd1;
    endfunction

    // The newest character is held back so that the last one of a byte can be flagged.
    task automatic put_char(input logic [20:0] cp, input bit term);
        t_decoded r;
        if (run_len < 4) begin
            if (have_held) begin
                decoded_q.push_back(held);
            end
            r.cp   = cp;
            r.cols = term ? 2'd0 : columns_of(cp);
            r.term = term;
            r.last = 1'b0;
            held = r;
            have_held = 1'b1;
            run_len++;
        end
    endtask

    task automatic put_replacements(input logic [2:0] n);
        int i;
        for (i = 0; i < n; i++) begin
            put_char(utf8cw_pkg::REPLACEMENT, 1'b0);
        end
    endtask

    task automatic drop_sequence();
        acc_bits = '0;
        seq_len  = utf8cw_pkg::LEN_NONE;
        seq_got  = '0;
    endtask

    // A byte seen with no sequence pending.
    task automatic open_or_single(input logic [7:0] b);
        if (b < 8'h80) begin
            put_char({13'd0, b}, 1'b0);
        end else if (b >= utf8cw_pkg::LEAD2_LO && b <= utf8cw_pkg::LEAD2_HI) begin
            seq_len = utf8cw_pkg::LEN_2; acc_bits = {16'd0, b[4:0]}; seq_got = 3'd1;
        end else if (b >= utf8cw_pkg::LEAD3_LO && b <= utf8cw_pkg::LEAD3_HI) begin
            seq_len = utf8cw_pkg::LEN_3; acc_bits = {17'd0, b[3:0]}; seq_got = 3'd1;
        end else if (b >= utf8cw_pkg::LEAD4_LO && b <= utf8cw_pkg::LEAD4_HI) begin
            seq_len = utf8cw_pkg::LEN_4; acc_bits = {18'd0, b[2:0]}; seq_got = 3'd1;
        end else begin
            put_char(utf8cw_pkg::REPLACEMENT, 1'b0);
        end
    endtask

    // Works out the characters that one accepted byte gives.
    task automatic decode_byte(input logic [7:0] b);
        logic [20:0] v;
        have_held = 1'b0;
        run_len   = 0;
        if (b == utf8cw_pkg::BYTE_NUL) begin
            if (seq_len != utf8cw_pkg::LEN_NONE) begin
                put_replacements(seq_got);
            end
            drop_sequence();
            put_char(21'd0, 1'b1);
        end else if (seq_len != utf8cw_pkg::LEN_NONE) begin
            if (b[7:6] == 2'b10) begin
                v = {acc_bits[14:0], b[5:0]};
                acc_bits = v;
                seq_got  = seq_got + 3'd1;
                if (seq_got >= seq_len) begin
                    if ((seq_len == utf8cw_pkg::LEN_3 && v < utf8cw_pkg::MIN_CP3) ||
                        (seq_len == utf8cw_pkg::LEN_4 && v < utf8cw_pkg::MIN_CP4) ||
                        v > utf8cw_pkg::MAX_CP ||
                        (v >= utf8cw_pkg::SURR_LO && v <= utf8cw_pkg::SURR_HI)) begin
                        put_replacements(seq_len);
                    end else begin
                        put_char(v, 1'b0);
                    end
                    drop_sequence();
                end
            end else begin
                put_replacements(seq_got);
                drop_sequence();
                open_or_single(b);
            end
        end else begin
            open_or_single(b);
        end
        if (have_held) begin
            held.last = 1'b1;
            decoded_q.push_back(held);
        end
    endtask

    // Driver: decodes each accepted beat, then offers the next byte or idles.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
        end else begin
            if (in_valid && in_ready) begin
                decode_byte(in_byte);
            end
            if (!in_valid || in_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    in_valid <= 1'b1;
                    in_byte  <= byte_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest expected character.
    always @(posedge clk) begin
        t_decoded want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat cp=%h", code_point));
                end else begin
                    want = decoded_q.pop_front();
                    if (code_point !== want.cp) begin
                        report_mismatch($sformatf("code point %h, want %h", code_point, want.cp));
                    end
                    if (cols_out !== want.cols) begin
                        report_mismatch($sformatf("width %0d, want %0d for %h",
                                                  cols_out, want.cols, want.cp));
                    end
                    if (end_marker !== want.term) begin
                        report_mismatch($sformatf("end marker %b, want %b", end_marker, want.term));
                    end
                    if (last_of_run !== want.last) begin
                        report_mismatch($sformatf("last of run %b, want %b for %h",
                                                  last_of_run, want.last, want.cp));
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        byte_q.push_back(b);
        bytes_queued++;
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    function automatic logic [7:0] lead_byte(input int len);
        if (len == 2) begin
            return 8'($urandom_range(utf8cw_pkg::LEAD2_HI, utf8cw_pkg::LEAD2_LO));
        end else if (len == 3) begin
            return 8'($urandom_range(utf8cw_pkg::LEAD3_HI, utf8cw_pkg::LEAD3_LO));
        end
        return 8'($urandom_range(utf8cw_pkg::LEAD4_HI, utf8cw_pkg::LEAD4_LO));
    endfunction

    // Mostly whole sequences with random content, plus broken ones and noise.
    task automatic queue_random_text();
        int kind;
        int len;
        int k;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 28) begin
            queue_byte(8'($urandom_range(8'h7F, 1)));
        end else if (kind < 70) begin
            len = (kind < 42) ? 2 : (kind < 56) ? 3 : 4;
            queue_byte(lead_byte(len));
            for (k = 1; k < len; k++) begin
                queue_byte(cont_byte());
            end
        end else if (kind < 80) begin
            // Sequence cut short by a byte that is not a continuation.
            len = $urandom_range(4, 2);
            queue_byte(lead_byte(len));
            for (k = $urandom_range(len - 2); k > 0; k--) begin
                queue_byte(cont_byte());
            end
            do begin
                b = 8'($urandom);
            end while (b[7:6] == 2'b10);
            queue_byte(b);
        end else if (kind < 88) begin
            queue_byte(8'($urandom));
        end else if (kind < 94) begin
            queue_byte(utf8cw_pkg::BYTE_NUL);
        end else if (kind < 97) begin
            queue_byte(8'($urandom_range(8'hC1, 8'h80)));
        end else begin
            queue_byte(8'($urandom_range(8'hFF, 8'hF5)));
        end
    endtask

    // Sequencer: reset, then one phase per idling mix, draining between phases.
    initial begin
        int phase;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;  stall_pct = 0;
                    // ASCII letter and DEL, good and rejected sequences, strays, a cut
                    // sequence and terminators with and without pending bytes.
                    byte_q = '{8'h41, 8'h7F, 8'hC2, 8'h80, 8'hF0, 8'h9F, 8'h8C, 8'h80,
                               8'hF4, 8'h90, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80,
                               8'hE4, 8'hB8, 8'h41, 8'h80, 8'hFF, 8'hF0, 8'h9F,
                               utf8cw_pkg::BYTE_NUL, utf8cw_pkg::BYTE_NUL};
                    bytes_queued = byte_q.size();
                end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            while (bytes_queued < 24 * (phase + 1) + 24) begin
                queue_random_text();
            end
            // Next phase waits until every byte is sent and every character has come back.
            while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0) begin
                @(posedge clk);
            end
        end
        repeat (20) @(posedge clk);
        if (decoded_q.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", decoded_q.size()));
        end
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule
